// ----- hdl/pig_pkg.sv -----
// ----------------------------------------------------------------------------
// pig_pkg
// Types and constants shared by the packet interval generator modules.
// ----------------------------------------------------------------------------
package pig_pkg;

	localparam int unsigned MODE_W  = 2;
	localparam int unsigned DRAW_W  = 16;
	localparam int unsigned NOW_W   = 32;
	localparam int unsigned PI_W    = 32;
	localparam int unsigned JHW_W   = 30;
	localparam int unsigned BURST_W = 31;
	localparam int unsigned OUT_W   = 33;
	localparam int unsigned MUL_A_W = 31;
	localparam int unsigned PROD_W  = MUL_A_W + DRAW_W;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned IN_TDATA_W = 4 * DRAW_W + NOW_W;
	localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QAW    = 1;
	localparam int unsigned QCW    = $clog2(QDEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POISSON  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_JITTER   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BURST    = 2'd3;

	localparam int unsigned FLAG_RANDOM_GAP = 0;
	localparam int unsigned FLAG_EXP_LENGTH = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_MODE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_FLAGS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PACKET_INTERVAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_JITTER_HW       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_GAP       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH    = 3'd6;

	localparam logic [PI_W-1:0]    RST_PACKET_INTERVAL = 32'd1000;
	localparam logic [BURST_W-1:0] RST_BURST_GAP       = 31'd1000000;
	localparam logic [BURST_W-1:0] RST_BURST_LENGTH    = 31'd100000;

	typedef struct packed {
		logic [MODE_W-1:0]  pattern_mode;
		logic [MODE_W-1:0]  inner_mode;
		logic [1:0]         burst_flags;
		logic [PI_W-1:0]    packet_interval;
		logic [BURST_W-1:0] burst_gap;
		logic [BURST_W-1:0] burst_length;
		logic [JHW_W-1:0]   jitter_hw;
		logic [PI_W-1:0]    jitter_lo;
	} cfg_t;

	typedef struct packed {
		logic               burst;
		logic [MODE_W-1:0]  mode;
		logic [DRAW_W-1:0]  exp_draw_packet;
		logic [DRAW_W-1:0]  exp_draw_gap;
		logic [DRAW_W-1:0]  exp_draw_length;
		logic [DRAW_W-1:0]  uniform_draw;
		logic [NOW_W-1:0]   now_us;
	} item_t;

endpackage

// ----- hdl/packet_interval_generator_top.sv -----
// ----------------------------------------------------------------------------
// packet_interval_generator_top
// Generates the next inter-packet interval for each request.
// ----------------------------------------------------------------------------
// Each request transfer yields one result transfer carrying the next interval in
// microseconds (-1 when paused) and a flag that marks the start of a burst. The
// back end runs a request's Poisson or jitter product, the burst gap product and
// the burst length product through one shared multiplier in turn, and takes the
// next request only once the last one is through. A two-entry request queue and
// a registered result let the input and output sides stall independently.
// Configuration writes are taken every cycle and must only be made while no
// request is pending.
module packet_interval_generator_top #(
	parameter int unsigned TIME_BITS      = 32,
	parameter int unsigned DRAW_FRAC_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// exp_draw_packet, exp_draw_gap, exp_draw_length, uniform_draw, now_us
	input  logic [pig_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// interval_us, zero padding
	output logic [pig_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// burst_started
	output logic                               m_axis_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pig_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pig_pkg::CFG_DATA_W-1:0]     cfg_data
);

	pig_pkg::cfg_t                  cfg;
	logic                           q_valid;
	pig_pkg::item_t                 q_item;
	logic                           q_pop;
	logic [pig_pkg::OUT_W-1:0]      interval_us;

	pig_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pig_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	pig_back #(
		.TIME_BITS      (TIME_BITS),
		.DRAW_FRAC_BITS (DRAW_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_interval (interval_us),
		.out_started  (m_axis_tuser)
	);

	assign m_axis_tdata = pig_pkg::OUT_TDATA_W'(interval_us);

endmodule

// ----- hdl/pig_cfg.sv -----
// ----------------------------------------------------------------------------
// pig_cfg
// Configuration registers and the jitter bounds derived from them.
// ----------------------------------------------------------------------------
module pig_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pig_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pig_pkg::CFG_DATA_W-1:0]     cfg_data,
	output pig_pkg::cfg_t                      cfg
);

	logic [pig_pkg::MODE_W-1:0]  pattern_mode_q;
	logic [pig_pkg::MODE_W-1:0]  inner_mode_q;
	logic [1:0]                  burst_flags_q;
	logic [pig_pkg::PI_W-1:0]    packet_interval_q;
	logic [pig_pkg::JHW_W-1:0]   jitter_hw_q;
	logic [pig_pkg::BURST_W-1:0] burst_gap_q;
	logic [pig_pkg::BURST_W-1:0] burst_length_q;
	logic [pig_pkg::JHW_W-1:0]   jitter_eff_q;
	logic [pig_pkg::PI_W-1:0]    jitter_lo_q;

	logic [pig_pkg::PI_W-2:0]    half_mean;
	logic [pig_pkg::JHW_W-1:0]   jitter_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_mode_q    <= pig_pkg::MODE_PERIODIC;
			inner_mode_q      <= pig_pkg::MODE_PERIODIC;
			burst_flags_q     <= 2'b00;
			packet_interval_q <= pig_pkg::RST_PACKET_INTERVAL;
			jitter_hw_q       <= '0;
			burst_gap_q       <= pig_pkg::RST_BURST_GAP;
			burst_length_q    <= pig_pkg::RST_BURST_LENGTH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pig_pkg::REG_PATTERN_MODE:    pattern_mode_q    <= cfg_data[pig_pkg::MODE_W-1:0];
				pig_pkg::REG_INNER_MODE:      inner_mode_q      <= cfg_data[pig_pkg::MODE_W-1:0];
				pig_pkg::REG_BURST_FLAGS:     burst_flags_q     <= cfg_data[1:0];
				pig_pkg::REG_PACKET_INTERVAL: packet_interval_q <= cfg_data[pig_pkg::PI_W-1:0];
				pig_pkg::REG_JITTER_HW:       jitter_hw_q       <= cfg_data[pig_pkg::JHW_W-1:0];
				pig_pkg::REG_BURST_GAP:       burst_gap_q       <= cfg_data[pig_pkg::BURST_W-1:0];
				pig_pkg::REG_BURST_LENGTH:    burst_length_q    <= cfg_data[pig_pkg::BURST_W-1:0];
				default: ;
			endcase
		end
	end

	// The half-width is limited to half of the mean interval.
	assign half_mean  = packet_interval_q[pig_pkg::PI_W-1:1];
	assign jitter_eff = ({1'b0, jitter_hw_q} > half_mean) ? half_mean[pig_pkg::JHW_W-1:0]
	                                                      : jitter_hw_q;

	always_ff @(posedge clk) begin
		jitter_eff_q <= jitter_eff;
		jitter_lo_q  <= packet_interval_q - pig_pkg::PI_W'(jitter_eff);
	end

	always_comb begin
		cfg.pattern_mode    = pattern_mode_q;
		cfg.inner_mode      = inner_mode_q;
		cfg.burst_flags     = burst_flags_q;
		cfg.packet_interval = packet_interval_q;
		cfg.burst_gap       = burst_gap_q;
		cfg.burst_length    = burst_length_q;
		cfg.jitter_hw       = jitter_eff_q;
		cfg.jitter_lo       = jitter_lo_q;
	end

endmodule

// ----- hdl/pig_front.sv -----
// ----------------------------------------------------------------------------
// pig_front
// Accepts requests, tags each with its pattern and queues it for the back end.
// ----------------------------------------------------------------------------
module pig_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pig_pkg::cfg_t                      cfg,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [pig_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                               q_valid,
	output pig_pkg::item_t                     q_item,
	input  logic                               q_pop
);

	pig_pkg::item_t              entry_q [pig_pkg::QDEPTH];
	logic [pig_pkg::QAW-1:0]     wr_ptr_q;
	logic [pig_pkg::QAW-1:0]     rd_ptr_q;
	logic [pig_pkg::QCW-1:0]     count_q;
	pig_pkg::item_t              in_item;
	logic                        push;
	logic                        pop;

	always_comb begin
		in_item.burst           = (cfg.pattern_mode == pig_pkg::MODE_BURST);
		in_item.mode            = in_item.burst ? cfg.inner_mode : cfg.pattern_mode;
		in_item.exp_draw_packet = s_axis_tdata[15:0];
		in_item.exp_draw_gap    = s_axis_tdata[31:16];
		in_item.exp_draw_length = s_axis_tdata[47:32];
		in_item.uniform_draw    = s_axis_tdata[63:48];
		in_item.now_us          = s_axis_tdata[95:64];
	end

	assign s_axis_tready = (count_q != pig_pkg::QCW'(pig_pkg::QDEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (count_q != '0);
	assign pop           = q_pop && q_valid;
	assign q_item        = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/pig_back.sv -----
// ----------------------------------------------------------------------------
// pig_back
// Four-step sequencer around one shared multiplier that computes the interval,
// keeps the jitter and burst state and holds the result register.
// ----------------------------------------------------------------------------
module pig_back #(
	parameter int unsigned TIME_BITS      = 32,
	parameter int unsigned DRAW_FRAC_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pig_pkg::cfg_t                      cfg,
	input  logic                               q_valid,
	input  pig_pkg::item_t                     q_item,
	output logic                               q_pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [pig_pkg::OUT_W-1:0]          out_interval,
	output logic                               out_started
);

	localparam int unsigned TW = TIME_BITS;
	localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;

	typedef enum logic [3:0] {
		ST_PKT  = 4'b0001,
		ST_GAP  = 4'b0010,
		ST_LEN  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                          state_q;
	pig_pkg::item_t                  item_q;
	logic [pig_pkg::PROD_W-1:0]      prod_q;
	logic [pig_pkg::OUT_W-1:0]       pk_q;
	logic [31:0]                     gap_q;
	logic                            done_q;
	logic                            timed_q;
	logic [31:0]                     rem_next_q;

	logic [pig_pkg::OUT_W-1:0]       carry_q;
	logic [31:0]                     rem_q;
	logic [31:0]                     dur_q;
	logic [TW-1:0]                   lst_q;
	logic                            lsv_q;

	logic                            out_valid_q;
	logic [pig_pkg::OUT_W-1:0]       out_interval_q;
	logic                            out_started_q;

	logic [pig_pkg::MUL_A_W-1:0]     mul_a;
	logic [pig_pkg::DRAW_W-1:0]      mul_b;
	logic [pig_pkg::PROD_W-1:0]      mul_p;

	logic                            pi_pos;
	logic [pig_pkg::OUT_W-1:0]       flat;
	logic [31:0]                     jit_pk;
	logic [34:0]                     jit_sum;
	logic [pig_pkg::OUT_W-1:0]       jit_res;
	logic [pig_pkg::OUT_W-1:0]       pk_inner;

	logic                            timed;
	logic [TW-1:0]                   now_m;
	logic [TW-1:0]                   base;
	logic [TW-1:0]                   delta;
	logic [31:0]                     dec;
	logic                            done;

	logic [31:0]                     dur_new;
	logic [32:0]                     bi_raw;
	logic [31:0]                     bi;
	logic [pig_pkg::OUT_W-1:0]       pk_fin;
	logic                            out_free;
	logic                            finish;

	function automatic logic [31:0] scale_sat(input logic [pig_pkg::PROD_W-1:0] p);
		logic [pig_pkg::PROD_W-1:0] sh;
		sh = p >> DRAW_FRAC_BITS;
		scale_sat = (|sh[pig_pkg::PROD_W-1:32]) ? 32'hFFFF_FFFF : sh[31:0];
	endfunction

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_PKT: begin
				if (q_item.mode == pig_pkg::MODE_JITTER) begin
					mul_a = {cfg.jitter_hw, 1'b0};
					mul_b = q_item.uniform_draw;
				end else begin
					mul_a = cfg.packet_interval[pig_pkg::MUL_A_W-1:0];
					mul_b = q_item.exp_draw_packet;
				end
			end
			ST_GAP: begin
				mul_a = cfg.burst_gap;
				mul_b = item_q.exp_draw_gap;
			end
			ST_LEN: begin
				mul_a = cfg.burst_length;
				mul_b = item_q.exp_draw_length;
			end
			default: ;
		endcase
	end

	assign mul_p = pig_pkg::PROD_W'(mul_a) * pig_pkg::PROD_W'(mul_b);

	// Interval of the base pattern. Any negative interval means paused.
	assign pi_pos  = !cfg.packet_interval[31] && (|cfg.packet_interval);
	assign flat    = cfg.packet_interval[31] ? '1 : {1'b0, cfg.packet_interval};
	assign jit_pk  = cfg.jitter_lo + 32'(prod_q[pig_pkg::PROD_W-1:16]);
	assign jit_sum = {3'b000, jit_pk} + {{2{carry_q[32]}}, carry_q};

	always_comb begin
		if (jit_sum[34]) begin
			jit_res = '0;
		end else if (|jit_sum[33:32]) begin
			jit_res = {1'b0, 32'hFFFF_FFFF};
		end else begin
			jit_res = {1'b0, jit_sum[31:0]};
		end
		case (item_q.mode)
			pig_pkg::MODE_POISSON: pk_inner = pi_pos ? {1'b0, scale_sat(prod_q)} : flat;
			pig_pkg::MODE_JITTER:  pk_inner = pi_pos ? jit_res : flat;
			default:               pk_inner = flat;
		endcase
	end

	// Burst on-time countdown, by elapsed time or by interval.
	assign timed = pk_q[32] || (pk_q == '0);
	assign now_m = TW'(item_q.now_us);
	assign base  = lsv_q ? lst_q : now_m;
	assign delta = now_m - base;
	assign done  = timed ? (CW'(rem_q) > CW'(delta)) : (rem_q > pk_q[31:0]);
	assign dec   = timed ? 32'(delta) : pk_q[31:0];

	// Start of the next burst.
	assign dur_new = cfg.burst_flags[pig_pkg::FLAG_EXP_LENGTH] ? scale_sat(prod_q)
	                                                           : {1'b0, cfg.burst_length};
	assign bi_raw  = (gap_q > dur_q) ? ({1'b0, gap_q} - {1'b0, dur_q} + {1'b0, rem_q})
	                                 : {1'b0, rem_q};
	assign bi      = bi_raw[32] ? 32'hFFFF_FFFF : bi_raw[31:0];

	always_comb begin
		if (!item_q.burst || done_q) begin
			pk_fin = pk_q;
		end else if (pk_q[32] || (bi > pk_q[31:0])) begin
			pk_fin = {1'b0, bi};
		end else begin
			pk_fin = pk_q;
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == ST_DONE) && out_free;
	assign q_pop    = (state_q == ST_PKT) && q_valid;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_PKT: begin
				if (q_valid) begin
					item_q <= q_item;
					prod_q <= mul_p;
				end
			end
			ST_GAP: begin
				pk_q   <= pk_inner;
				prod_q <= mul_p;
			end
			ST_LEN: begin
				gap_q      <= cfg.burst_flags[pig_pkg::FLAG_RANDOM_GAP] ? scale_sat(prod_q)
				                                                        : {1'b0, cfg.burst_gap};
				prod_q     <= mul_p;
				done_q     <= done;
				timed_q    <= timed;
				rem_next_q <= rem_q - dec;
			end
			default: ;
		endcase
		if (finish) begin
			out_interval_q <= pk_fin;
			out_started_q  <= item_q.burst && !done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_PKT;
			out_valid_q <= 1'b0;
			carry_q     <= '0;
			rem_q       <= 32'(pig_pkg::RST_BURST_LENGTH);
			dur_q       <= 32'(pig_pkg::RST_BURST_LENGTH);
			lst_q       <= '0;
			lsv_q       <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_PKT: begin
					if (q_valid) begin
						state_q <= ST_GAP;
					end
				end
				ST_GAP: begin
					if (item_q.mode == pig_pkg::MODE_JITTER) begin
						carry_q <= pi_pos ? ({1'b0, cfg.packet_interval} - {1'b0, jit_pk}) : '0;
					end
					state_q <= ST_LEN;
				end
				ST_LEN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_PKT;
						if (item_q.burst) begin
							if (timed_q) begin
								lst_q <= now_m;
								lsv_q <= done_q;
							end
							if (done_q) begin
								rem_q <= rem_next_q;
							end else begin
								rem_q <= dur_new;
								dur_q <= dur_new;
							end
						end
					end
				end
				default: begin
					state_q <= ST_PKT;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_interval = out_interval_q;
	assign out_started  = out_started_q;

endmodule
